>>> rtl/cfti_pkg.sv
// Shared types and constants of the coolant flow and temperature interlock.
`timescale 1ns / 1ps

package cfti_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_TEMP_CHECK_ON  = 3'd0,
		CFG_FLOW_CHECK_ON  = 3'd1,
		CFG_TEMP_WARN_DEG  = 3'd2,
		CFG_TEMP_ALARM_DEG = 3'd3,
		CFG_FLOW_WARN_LPH  = 3'd4,
		CFG_FLOW_ALARM_LPH = 3'd5,
		CFG_WINDOW_TICKS   = 3'd6
	} cfg_idx_t;

	// Event codes reported with every result item.
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_TEMP_WARN  = 3'd1,
		EV_TEMP_ALARM = 3'd2,
		EV_FLOW_WARN  = 3'd3,
		EV_FLOW_ALARM = 3'd4
	} event_t;

	localparam int CfgIdxWidth  = 3;
	localparam int CfgDataWidth = 16;

	// Register values after reset.
	localparam logic        RstTempCheckOn  = 1'b1;
	localparam logic        RstFlowCheckOn  = 1'b1;
	localparam logic [7:0]  RstTempWarnDeg  = 8'd30;
	localparam logic [7:0]  RstTempAlarmDeg = 8'd40;
	localparam logic [7:0]  RstFlowWarnLph  = 8'd100;
	localparam logic [7:0]  RstFlowAlarmLph = 8'd50;
	localparam logic [15:0] RstWindowTicks  = 16'd1000;

	// Full set of configuration registers.
	typedef struct packed {
		logic        temp_check_on;
		logic        flow_check_on;
		logic [7:0]  temp_warn_deg;
		logic [7:0]  temp_alarm_deg;
		logic [7:0]  flow_warn_lph;
		logic [7:0]  flow_alarm_lph;
		logic [15:0] window_ticks;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic [3:0]        flow_pulses;
		logic              ms_tick;
		logic signed [11:0] temp_sample;
		logic              sensor_present;
		logic              clear_halt;
	} sample_t;

	// One result item.
	typedef struct packed {
		event_t      event_code;
		logic        halted;
		logic        estop;
		logic [15:0] flow_now;
		logic [10:0] temp_now;
		logic        temp_warning;
		logic        flow_warning;
		logic        value_changed;
	} result_t;

endpackage

>>> rtl/cfti_if.sv
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps

interface cfti_sample_if;
	logic               valid;
	logic               ready;
	logic [3:0]         flow_pulses;
	logic               ms_tick;
	logic signed [11:0] temp_sample;
	logic               sensor_present;
	logic               clear_halt;

	modport source (output valid, flow_pulses, ms_tick, temp_sample, sensor_present,
		clear_halt, input ready);
	modport sink (input valid, flow_pulses, ms_tick, temp_sample, sensor_present,
		clear_halt, output ready);
endinterface

interface cfti_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_code;
	logic        halted;
	logic        estop;
	logic [15:0] flow_now;
	logic [10:0] temp_now;
	logic        temp_warning;
	logic        flow_warning;
	logic        value_changed;

	modport source (output valid, event_code, halted, estop, flow_now, temp_now,
		temp_warning, flow_warning, value_changed, input ready);
	modport sink (input valid, event_code, halted, estop, flow_now, temp_now,
		temp_warning, flow_warning, value_changed, output ready);
endinterface

interface cfti_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cfti_pkg::CfgIdxWidth-1:0]  index;
	logic [cfti_pkg::CfgDataWidth-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

>>> rtl/cfti_cfg_regs.sv
// Configuration register file of the interlock.
`timescale 1ns / 1ps

module cfti_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [cfti_pkg::CfgIdxWidth-1:0]  wr_index,
	input  logic [cfti_pkg::CfgDataWidth-1:0] wr_data,
	output cfti_pkg::cfg_t                    cfg
);

	cfti_pkg::cfg_t cfg_q;

	// Write one register per handshake; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_check_on  <= cfti_pkg::RstTempCheckOn;
			cfg_q.flow_check_on  <= cfti_pkg::RstFlowCheckOn;
			cfg_q.temp_warn_deg  <= cfti_pkg::RstTempWarnDeg;
			cfg_q.temp_alarm_deg <= cfti_pkg::RstTempAlarmDeg;
			cfg_q.flow_warn_lph  <= cfti_pkg::RstFlowWarnLph;
			cfg_q.flow_alarm_lph <= cfti_pkg::RstFlowAlarmLph;
			cfg_q.window_ticks   <= cfti_pkg::RstWindowTicks;
		end else if (wr_en) begin
			unique case (cfti_pkg::cfg_idx_t'(wr_index))
				cfti_pkg::CFG_TEMP_CHECK_ON:  cfg_q.temp_check_on  <= wr_data[0];
				cfti_pkg::CFG_FLOW_CHECK_ON:  cfg_q.flow_check_on  <= wr_data[0];
				cfti_pkg::CFG_TEMP_WARN_DEG:  cfg_q.temp_warn_deg  <= wr_data[7:0];
				cfti_pkg::CFG_TEMP_ALARM_DEG: cfg_q.temp_alarm_deg <= wr_data[7:0];
				cfti_pkg::CFG_FLOW_WARN_LPH:  cfg_q.flow_warn_lph  <= wr_data[7:0];
				cfti_pkg::CFG_FLOW_ALARM_LPH: cfg_q.flow_alarm_lph <= wr_data[7:0];
				cfti_pkg::CFG_WINDOW_TICKS:   cfg_q.window_ticks   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/cfti_step.sv
// Measuring state and the threshold checks for one item.
`timescale 1ns / 1ps

module cfti_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  cfti_pkg::sample_t   sample,
	input  cfti_pkg::cfg_t      cfg,
	output cfti_pkg::result_t   result
);

	logic [15:0] pulse_q, elapsed_q, flow_q;
	logic [10:0] temp_q;
	logic        halt_q, estop_q;

	logic [15:0] pulse_c, elapsed_c, flow_c, win, flow_meas;
	logic [10:0] temp_c, temp_meas;
	logic [16:0] psum;
	logic [11:0] temp_warn_lim, temp_alarm_lim;
	logic        halt_c, estop_c, changed;
	logic        t_warn, t_alarm, f_warn, f_alarm;
	cfti_pkg::event_t code;

	// Clear, then measuring while not halted, then the checks on the held values.
	always_comb begin
		halt_c    = halt_q & ~sample.clear_halt;
		pulse_c   = sample.clear_halt ? 16'd0 : pulse_q;
		elapsed_c = sample.clear_halt ? 16'd0 : elapsed_q;
		flow_c    = flow_q;
		temp_c    = temp_q;
		changed   = 1'b0;
		win       = (cfg.window_ticks == 16'd0) ? 16'd1 : cfg.window_ticks;
		psum      = {1'b0, pulse_c} + {13'd0, sample.flow_pulses};
		flow_meas = 16'd0;
		temp_meas = 11'd0;

		if (!halt_c) begin
			pulse_c = psum[16] ? 16'hFFFF : psum[15:0];
			if (sample.ms_tick && elapsed_c != 16'hFFFF) begin
				elapsed_c = elapsed_c + 16'd1;
			end
			// Pulses times eight, saturating.
			flow_meas = (pulse_c[15:13] != 3'd0) ? 16'hFFFF : {pulse_c[12:0], 3'b000};
			// Negative samples and a missing sensor read as zero.
			temp_meas = (sample.sensor_present && !sample.temp_sample[11]) ?
				sample.temp_sample[10:0] : 11'd0;
			if (elapsed_c >= win) begin
				changed   = (flow_meas != flow_q) || (temp_meas != temp_q);
				flow_c    = flow_meas;
				temp_c    = temp_meas;
				pulse_c   = 16'd0;
				elapsed_c = 16'd0;
			end
		end

		// Degree thresholds scaled to tenths: x*8 + x*2.
		temp_warn_lim  = 12'({cfg.temp_warn_deg, 3'b000}) + 12'({cfg.temp_warn_deg, 1'b0});
		temp_alarm_lim = 12'({cfg.temp_alarm_deg, 3'b000}) + 12'({cfg.temp_alarm_deg, 1'b0});

		t_warn  = 1'b0;
		t_alarm = 1'b0;
		f_warn  = 1'b0;
		f_alarm = 1'b0;
		if (cfg.temp_check_on && sample.sensor_present) begin
			t_warn  = ({1'b0, temp_c} >= temp_warn_lim) && ({1'b0, temp_c} < temp_alarm_lim);
			t_alarm = {1'b0, temp_c} >= temp_alarm_lim;
		end
		if (cfg.flow_check_on) begin
			f_warn  = (flow_c > {8'd0, cfg.flow_alarm_lph}) &&
				(flow_c <= {8'd0, cfg.flow_warn_lph});
			f_alarm = flow_c <= {8'd0, cfg.flow_alarm_lph};
		end

		// Alarms latch halt and drive the stop; warnings keep the stop level.
		estop_c = estop_q;
		priority if (t_alarm) begin
			code    = cfti_pkg::EV_TEMP_ALARM;
			estop_c = 1'b1;
			halt_c  = 1'b1;
		end else if (f_alarm) begin
			code    = cfti_pkg::EV_FLOW_ALARM;
			estop_c = 1'b1;
			halt_c  = 1'b1;
		end else if (t_warn) begin
			code = cfti_pkg::EV_TEMP_WARN;
		end else if (f_warn) begin
			code = cfti_pkg::EV_FLOW_WARN;
		end else begin
			code    = cfti_pkg::EV_NONE;
			estop_c = 1'b0;
		end
	end

	// State advances once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q   <= 16'd0;
			elapsed_q <= 16'd0;
			flow_q    <= 16'd0;
			temp_q    <= 11'd0;
			halt_q    <= 1'b0;
			estop_q   <= 1'b0;
		end else if (fire) begin
			pulse_q   <= pulse_c;
			elapsed_q <= elapsed_c;
			flow_q    <= flow_c;
			temp_q    <= temp_c;
			halt_q    <= halt_c;
			estop_q   <= estop_c;
		end
	end

	always_comb begin
		result.event_code    = code;
		result.halted        = halt_c;
		result.estop         = estop_c;
		result.flow_now      = flow_c;
		result.temp_now      = temp_c;
		result.temp_warning  = t_warn;
		result.flow_warning  = f_warn;
		result.value_changed = changed;
	end

endmodule

>>> rtl/coolant_flow_temp_interlock.sv
// Top level of the coolant flow and temperature interlock.
//
// Usage:
// Each item on the sample channel carries the flow pulses seen since the last
// item, a millisecond tick, the temperature sample and the clear request. Every
// sample item yields exactly one item on the result channel with the event code,
// halt and stop levels, the held flow and temperature and the warning flags.
// Registers are written over the cfg channel, which is always ready; write only
// while no item is in flight.
// The item is held in the input register, then the measuring state and the checks
// update in a single pass and load the result register. One item is accepted every
// cycle while the receiver takes results.
// When the receiver stalls, the result register holds its item and the input
// register fills; the sample channel drops ready once both are occupied.
// Reset clears the measuring state, the halt latch and the stop level, and loads
// the default thresholds and a window of 1000 ticks. No clearing pass is needed.
`timescale 1ns / 1ps

module coolant_flow_temp_interlock (
	input  logic                 clk,
	input  logic                 arst_n,
	cfti_sample_if.sink          sample,
	cfti_result_if.source        result,
	cfti_cfg_if.sink             cfg
);

	cfti_pkg::cfg_t    cfg_regs;
	cfti_pkg::sample_t sample_s1;
	cfti_pkg::result_t step_res;
	cfti_pkg::result_t result_q;
	logic              valid_s1, out_valid_q, advance, fire, take;

	assign cfg.ready = 1'b1;

	cfti_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.cfg      (cfg_regs)
	);

	// Handshake control: the output register frees the input stage.
	assign advance      = !out_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1.flow_pulses    <= sample.flow_pulses;
			sample_s1.ms_tick        <= sample.ms_tick;
			sample_s1.temp_sample    <= sample.temp_sample;
			sample_s1.sensor_present <= sample.sensor_present;
			sample_s1.clear_halt     <= sample.clear_halt;
		end
	end

	cfti_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.sample (sample_s1),
		.cfg    (cfg_regs),
		.result (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= step_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.event_code    = result_q.event_code;
	assign result.halted        = result_q.halted;
	assign result.estop         = result_q.estop;
	assign result.flow_now      = result_q.flow_now;
	assign result.temp_now      = result_q.temp_now;
	assign result.temp_warning  = result_q.temp_warning;
	assign result.flow_warning  = result_q.flow_warning;
	assign result.value_changed = result_q.value_changed;

	// An alarm always comes with halt and stop asserted.
	a_alarm_halts: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.event_code == cfti_pkg::EV_TEMP_ALARM ||
		result.event_code == cfti_pkg::EV_FLOW_ALARM) |-> result.halted && result.estop)
		else $error("alarm without halt and stop");

	// With no event the stop is released.
	a_none_releases: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.event_code == cfti_pkg::EV_NONE |-> !result.estop)
		else $error("stop held with no event");

	// An accepted item occupies the input stage in the next cycle.
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted item lost from input stage");

endmodule

>>> sim/coolant_interlock_checker.sv
// Checker for the coolant interlock: tracks registers, predicts every status item and compares.
`timescale 1ns / 1ps

module coolant_interlock_checker
	import cfti_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	cfti_sample_if smp,
	cfti_result_if res,
	cfti_cfg_if    cw,
	output int     fail_count,
	output int     pending
);

	// Register copy and measuring state of the predicted interlock.
	cfg_t        regs;
	int          pulse_acc;
	int          ticks_seen;
	int          flow_lph;
	int          temp_dd;
	logic        halt_on;
	logic        estop_on;
	result_t     status_due[$];

	// Works out the status item for one reading and advances the measuring state.
	function automatic result_t predict_status(input sample_t s);
		result_t r;
		int win;
		int flow_calc;
		int temp_calc;
		int warn_lim;
		int alarm_lim;
		logic t_warn;
		logic t_alarm;
		logic f_warn;
		logic f_alarm;
		logic changed;

		t_warn = 1'b0;
		t_alarm = 1'b0;
		f_warn = 1'b0;
		f_alarm = 1'b0;
		changed = 1'b0;

		// A clear releases the halt and restarts the window.
		if (s.clear_halt) begin
			halt_on = 1'b0;
			pulse_acc = 0;
			ticks_seen = 0;
		end

		// Measuring is frozen while halted.
		if (!halt_on) begin
			win = (regs.window_ticks == 16'd0) ? 1 : int'(regs.window_ticks);
			pulse_acc = pulse_acc + int'(s.flow_pulses);
			if (pulse_acc > 65535) pulse_acc = 65535;
			if (s.ms_tick && ticks_seen < 65535) ticks_seen++;
			if (ticks_seen >= win) begin
				flow_calc = pulse_acc * 8;
				if (flow_calc > 65535) flow_calc = 65535;
				temp_calc = 0;
				if (s.sensor_present && !s.temp_sample[11]) begin
					temp_calc = int'(s.temp_sample[10:0]);
				end
				if (flow_calc != flow_lph) begin
					flow_lph = flow_calc;
					changed = 1'b1;
				end
				if (temp_calc != temp_dd) begin
					temp_dd = temp_calc;
					changed = 1'b1;
				end
				pulse_acc = 0;
				ticks_seen = 0;
			end
		end

		// Threshold checks run on the held values every item.
		if (regs.temp_check_on && s.sensor_present) begin
			warn_lim = int'(regs.temp_warn_deg) * 10;
			alarm_lim = int'(regs.temp_alarm_deg) * 10;
			t_warn = (temp_dd >= warn_lim) && (temp_dd < alarm_lim);
			t_alarm = (temp_dd >= alarm_lim);
		end
		if (regs.flow_check_on) begin
			f_warn = (flow_lph > int'(regs.flow_alarm_lph)) &&
				(flow_lph <= int'(regs.flow_warn_lph));
			f_alarm = (flow_lph <= int'(regs.flow_alarm_lph));
		end

		// Alarms latch halt and raise the stop; only a quiet item drops the stop.
		if (t_alarm) begin
			r.event_code = EV_TEMP_ALARM;
			estop_on = 1'b1;
			halt_on = 1'b1;
		end else if (f_alarm) begin
			r.event_code = EV_FLOW_ALARM;
			estop_on = 1'b1;
			halt_on = 1'b1;
		end else if (t_warn) begin
			r.event_code = EV_TEMP_WARN;
		end else if (f_warn) begin
			r.event_code = EV_FLOW_WARN;
		end else begin
			r.event_code = EV_NONE;
			estop_on = 1'b0;
		end

		r.halted = halt_on;
		r.estop = estop_on;
		r.flow_now = flow_lph[15:0];
		r.temp_now = temp_dd[10:0];
		r.temp_warning = t_warn;
		r.flow_warning = f_warn;
		r.value_changed = changed;
		return r;
	endfunction

	// Reports one field that differs from its prediction.
	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Watch the three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		sample_t got_in;
		if (!arst_n) begin
			regs.temp_check_on = RstTempCheckOn;
			regs.flow_check_on = RstFlowCheckOn;
			regs.temp_warn_deg = RstTempWarnDeg;
			regs.temp_alarm_deg = RstTempAlarmDeg;
			regs.flow_warn_lph = RstFlowWarnLph;
			regs.flow_alarm_lph = RstFlowAlarmLph;
			regs.window_ticks = RstWindowTicks;
			pulse_acc = 0;
			ticks_seen = 0;
			flow_lph = 0;
			temp_dd = 0;
			halt_on = 1'b0;
			estop_on = 1'b0;
			status_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Register writes.
			if (cw.valid && cw.ready) begin
				case (cw.index)
					CFG_TEMP_CHECK_ON:  regs.temp_check_on = cw.wdata[0];
					CFG_FLOW_CHECK_ON:  regs.flow_check_on = cw.wdata[0];
					CFG_TEMP_WARN_DEG:  regs.temp_warn_deg = cw.wdata[7:0];
					CFG_TEMP_ALARM_DEG: regs.temp_alarm_deg = cw.wdata[7:0];
					CFG_FLOW_WARN_LPH:  regs.flow_warn_lph = cw.wdata[7:0];
					CFG_FLOW_ALARM_LPH: regs.flow_alarm_lph = cw.wdata[7:0];
					CFG_WINDOW_TICKS:   regs.window_ticks = cw.wdata;
					default: ;
				endcase
			end

			// Status items are compared with the oldest prediction.
			if (res.valid && res.ready) begin
				if (status_due.size() == 0) begin
					$display("%0t: status item arrived with none expected", $time);
					fail_count++;
				end else begin
					want = status_due.pop_front();
					check_field("event_code", want.event_code, res.event_code);
					check_field("halted", want.halted, res.halted);
					check_field("estop", want.estop, res.estop);
					check_field("flow_now", want.flow_now, res.flow_now);
					check_field("temp_now", want.temp_now, res.temp_now);
					check_field("temp_warning", want.temp_warning, res.temp_warning);
					check_field("flow_warning", want.flow_warning, res.flow_warning);
					check_field("value_changed", want.value_changed, res.value_changed);
				end
			end

			// Every accepted reading yields one predicted status item.
			if (smp.valid && smp.ready) begin
				got_in.flow_pulses = smp.flow_pulses;
				got_in.ms_tick = smp.ms_tick;
				got_in.temp_sample = smp.temp_sample;
				got_in.sensor_present = smp.sensor_present;
				got_in.clear_halt = smp.clear_halt;
				status_due.push_back(predict_status(got_in));
			end
			pending = status_due.size();
		end
	end

endmodule

>>> sim/coolant_flow_temp_interlock_tb.sv
// Top of the coolant interlock testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module coolant_flow_temp_interlock_tb;
	import cfti_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   src_idle_pct;
	int   dst_idle_pct;
	int   hold_requests;

	cfti_sample_if sample_ch ();
	cfti_result_if result_ch ();
	cfti_cfg_if    cfg_ch ();

	coolant_flow_temp_interlock DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	coolant_interlock_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (sample_ch),
		.res        (result_ch),
		.cw         (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Status receiver: random stalls, plus a long hold-off when requested.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				result_ch.ready = ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	function automatic sample_t reading(input int pulses, input bit tick, input int temp,
			input bit present, input bit clear);
		sample_t s;
		s.flow_pulses = pulses[3:0];
		s.ms_tick = tick;
		s.temp_sample = temp[11:0];
		s.sensor_present = present;
		s.clear_halt = clear;
		return s;
	endfunction

	function automatic sample_t random_reading();
		sample_t s;
		s.flow_pulses = 4'($urandom());
		s.ms_tick = ($urandom_range(9) < 6);
		if ($urandom_range(4) == 0) begin
			s.temp_sample = 12'($urandom());
		end else begin
			s.temp_sample = 12'(int'($urandom_range(1800)) - 550);
		end
		s.sensor_present = ($urandom_range(9) != 0);
		s.clear_halt = ($urandom_range(9) == 0);
		return s;
	endfunction

	function automatic cfg_t settings(input bit tc, input bit fc, input int tw, input int ta,
			input int fw, input int fa, input int win);
		cfg_t c;
		c.temp_check_on = tc;
		c.flow_check_on = fc;
		c.temp_warn_deg = tw[7:0];
		c.temp_alarm_deg = ta[7:0];
		c.flow_warn_lph = fw[7:0];
		c.flow_alarm_lph = fa[7:0];
		c.window_ticks = win[15:0];
		return c;
	endfunction

	// Mostly sensible thresholds with short windows; now and then an inverted pair.
	function automatic cfg_t random_settings();
		int tw;
		int ta;
		int fa;
		tw = $urandom_range(110, 20);
		ta = ($urandom_range(4) == 0) ? $urandom_range(255) : tw + $urandom_range(40);
		fa = $urandom_range(120);
		return settings($urandom_range(3) != 0, $urandom_range(3) != 0, tw, ta,
			fa + $urandom_range(135), fa, $urandom_range(6, 1));
	endfunction

	// Offers one reading, after a random gap, and returns once it is taken.
	task automatic send_reading(input sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid = 1'b0;
			sample_ch.flow_pulses = 4'($urandom());
			sample_ch.temp_sample = 12'($urandom());
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.flow_pulses = s.flow_pulses;
		sample_ch.ms_tick = s.ms_tick;
		sample_ch.temp_sample = s.temp_sample;
		sample_ch.sensor_present = s.sensor_present;
		sample_ch.clear_halt = s.clear_halt;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	// Stops offering readings until every status item is back and the pipe is empty.
	task automatic wait_drained();
		sample_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Leaves valid high so that back-to-back writes need no extra edge.
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.wdata = val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Writes all registers; unused upper data bits carry noise.
	task automatic load_settings(input cfg_t c);
		write_reg(CFG_TEMP_CHECK_ON, {15'($urandom()), c.temp_check_on});
		write_reg(CFG_FLOW_CHECK_ON, {15'($urandom()), c.flow_check_on});
		write_reg(CFG_TEMP_WARN_DEG, {8'($urandom()), c.temp_warn_deg});
		write_reg(CFG_TEMP_ALARM_DEG, {8'($urandom()), c.temp_alarm_deg});
		write_reg(CFG_FLOW_WARN_LPH, {8'($urandom()), c.flow_warn_lph});
		write_reg(CFG_FLOW_ALARM_LPH, {8'($urandom()), c.flow_alarm_lph});
		write_reg(CFG_WINDOW_TICKS, c.window_ticks);
		cfg_ch.valid = 1'b0;
	endtask

	// Stimulus.
	initial begin
		int phase;
		int k;
		arst_n = 1'b0;
		src_idle_pct = 22;
		dst_idle_pct = 72;
		hold_requests = 0;
		sample_ch.valid = 1'b0;
		sample_ch.flow_pulses = '0;
		sample_ch.ms_tick = 1'b0;
		sample_ch.temp_sample = '0;
		sample_ch.sensor_present = 1'b0;
		sample_ch.clear_halt = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_TEMP_CHECK_ON;
		cfg_ch.wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset thresholds: zero flow trips the flow alarm, and a clear trips it again.
		send_reading(reading(3, 1, 250, 1, 0));
		send_reading(reading(15, 1, 1250, 1, 1));

		// Temperature checks only, one-tick window.
		wait_drained();
		load_settings(settings(1, 0, 50, 80, 200, 100, 1));
		send_reading(reading(15, 1, 1250, 1, 1));
		send_reading(reading(15, 1, 600, 1, 0));
		send_reading(reading(15, 1, 600, 1, 1));
		send_reading(reading(15, 1, 600, 1, 0));
		send_reading(reading(4, 1, -550, 1, 0));
		send_reading(reading(0, 1, -1, 1, 0));
		send_reading(reading(0, 1, 2047, 1, 0));
		send_reading(reading(9, 1, -2048, 1, 1));
		send_reading(reading(2, 1, 1000, 0, 0));
		send_reading(reading(5, 1, 790, 1, 0));
		send_reading(reading(5, 0, 790, 0, 0));
		send_reading(reading(5, 0, 800, 1, 0));

		// Flow checks only, zero window acts as one tick.
		wait_drained();
		load_settings(settings(0, 1, 0, 0, 255, 0, 0));
		send_reading(reading(0, 1, 0, 1, 0));
		send_reading(reading(0, 0, 0, 1, 0));
		send_reading(reading(0, 1, 0, 1, 0));
		send_reading(reading(15, 1, 0, 1, 1));
		send_reading(reading(15, 0, 0, 1, 0));
		send_reading(reading(0, 1, 0, 1, 0));

		// One-tick window reached only after a long run without ticks, so the flow saturates at the window end.
		wait_drained();
		load_settings(settings(0, 0, 30, 40, 100, 50, 1));
		src_idle_pct = 0;
		dst_idle_pct = 0;
		for (k = 0; k < 550; k++) send_reading(reading(15, 0, 300, 1, 0));
		send_reading(reading(15, 1, 300, 1, 0));

		// Random phases, including the all-zero and all-max register extremes.
		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				1: load_settings(settings(1, 1, 0, 0, 0, 0, 0));
				3: load_settings(settings(1, 1, 255, 255, 255, 255, 65535));
				default: load_settings(random_settings());
			endcase
			src_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 72 : 0;
			dst_idle_pct = (phase < 2) ? 72 : (phase < 4) ? 22 : 0;
			for (k = 0; k < 30; k++) begin
				// Back up the block with a long receiver hold-off, later drain it fully.
				if (phase == 4 && k == 10) hold_requests++;
				if (phase == 4 && k == 20) wait_drained();
				send_reading(random_reading());
			end
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
